// ===== src/ttdf_pkg.sv =====
// Shared constants and control types for the two-way tag duplicate filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ttdf_pkg;

  localparam int INDEX_BITS  = 14;
  localparam int VERTEX_BITS = 32;
  localparam int TAG_BITS    = VERTEX_BITS - INDEX_BITS;
  localparam int DEPTH       = 1 << INDEX_BITS;

  localparam logic [TAG_BITS-1:0] EMPTY_TAG = TAG_BITS'(32'h0000_FFFF);

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_VERTEX = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  typedef struct packed {
    logic capture;   // latch the vertex and read its table row
    logic wr_en;     // write the tag into one way of the row
    logic wr_way;    // way that takes the tag
    logic clr_en;    // write one empty row of the clearing sweep
    logic out_load;  // load the output register
    logic out_done;  // loaded beat is the end-of-pass marker
  } cmd_t;

  typedef struct packed {
    logic hit;       // tag found in either way
    logic out_free;  // output register can take a beat this cycle
    logic clr_last;  // sweep is at the last row
  } status_t;

endpackage

`default_nettype wire

// ===== src/ttdf_ctrl.sv =====
// Controller for the duplicate filter: item sequencing, clear sweep, way pointer.
// Depends on ttdf_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none

module ttdf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        op,
  input  wire logic [6:0]        level,
  input  wire ttdf_pkg::status_t status,
  output ttdf_pkg::cmd_t         cmd
);
  import ttdf_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_EMIT
  } state_t;

  state_t state, state_next;
  logic   next_way, next_way_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    state_next    = state;
    next_way_next = next_way;
    cmd           = '0;
    cmd.wr_way    = next_way;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_START: begin
              next_way_next = 1'b0;
              if (level == 7'd0) begin
                state_next = S_CLEAR;
              end
            end
            OP_VERTEX: begin
              cmd.capture = 1'b1;
              state_next  = S_LOOKUP;
            end
            OP_END: begin
              state_next = S_EMIT;
            end
            default: begin
              // unused opcode: drop the beat
            end
          endcase
        end
      end
      S_LOOKUP: begin
        if (status.hit) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.wr_en     = 1'b1;
          cmd.out_load  = 1'b1;
          next_way_next = ~next_way;
          state_next    = S_IDLE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_done = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      next_way <= 1'b0;
    end else begin
      state    <= state_next;
      next_way <= next_way_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/ttdf_datapath.sv =====
// Datapath for the duplicate filter: tag table memory, compare, clear sweep counter
// and output register. Depends on ttdf_pkg; commanded by ttdf_ctrl.
`default_nettype none

module ttdf_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [ttdf_pkg::VERTEX_BITS-1:0] vertex,
  input  wire ttdf_pkg::cmd_t                   cmd,
  output ttdf_pkg::status_t                     status,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ttdf_pkg::VERTEX_BITS-1:0]      vertex_out,
  output logic                                  is_done
);
  import ttdf_pkg::*;

  // Row layout: way 1 in the upper half, way 0 in the lower half.
  logic [2*TAG_BITS-1:0]    tag_mem [DEPTH];
  logic [2*TAG_BITS-1:0]    rd_row;
  logic [VERTEX_BITS-1:0]   vertex_q;
  logic [INDEX_BITS-1:0]    clr_cnt;
  logic [INDEX_BITS-1:0]    idx_q;
  logic [TAG_BITS-1:0]      tag_q;
  logic [TAG_BITS-1:0]      way0_tag, way1_tag;
  logic [INDEX_BITS-1:0]    wr_addr;
  logic [2*TAG_BITS-1:0]    wr_row;
  logic                     mem_we;

  assign idx_q    = vertex_q[INDEX_BITS-1:0];
  assign tag_q    = vertex_q[VERTEX_BITS-1:INDEX_BITS];
  assign way0_tag = rd_row[TAG_BITS-1:0];
  assign way1_tag = rd_row[2*TAG_BITS-1:TAG_BITS];

  assign status.hit      = (way0_tag == tag_q) || (way1_tag == tag_q);
  assign status.out_free = !out_valid || !out_stall;
  assign status.clr_last = (clr_cnt == {INDEX_BITS{1'b1}});

  // Keep the other way of the row as read during the lookup.
  always_comb begin
    mem_we  = cmd.clr_en || cmd.wr_en;
    wr_addr = cmd.clr_en ? clr_cnt : idx_q;
    if (cmd.clr_en) begin
      wr_row = {EMPTY_TAG, EMPTY_TAG};
    end else if (cmd.wr_way) begin
      wr_row = {tag_q, way0_tag};
    end else begin
      wr_row = {way1_tag, tag_q};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[wr_addr] <= wr_row;
    end
    if (cmd.capture) begin
      rd_row <= tag_mem[vertex[INDEX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vertex_q <= vertex;
    end
    if (cmd.out_load) begin
      vertex_out <= cmd.out_done ? '0 : vertex_q;
      is_done    <= cmd.out_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // advance the sweep; it wraps back to row 0 after the last row
      if (cmd.clr_en) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/two_way_tag_duplicate_filter.sv =====
// Top level of the two-way tag duplicate filter.
// Depends on ttdf_pkg, ttdf_ctrl and ttdf_datapath.
//
// Usage: items enter on the in channel (in_valid/in_stall with op, level,
// vertex); results leave on the out channel (out_valid/out_stall with
// vertex_out, is_done). A beat moves when valid is high and stall is low.
// A vertex beat reads its table row at the accepting edge and compares it in
// the next cycle, then is dropped or written back and loaded into the output
// register: a new vertex is captured with its row and then passes the output
// register, and a vertex or end beat holds in_stall high until its lookup or
// emit step is done. A start beat with nonzero level only resets the way
// pointer. A start beat with level 0 and reset both run a clearing sweep of
// all 16384 rows (one table row per cycle, set by the single write port of the
// tag memory) while in_stall is high. An end beat yields a done marker with
// vertex_out zero. The output register holds a beat while out_stall is high;
// a result waiting behind it holds the block in its lookup or emit step.
`default_nettype none

module two_way_tag_duplicate_filter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       op,
  input  wire logic [6:0]                       level,
  input  wire logic [ttdf_pkg::VERTEX_BITS-1:0] vertex,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ttdf_pkg::VERTEX_BITS-1:0]      vertex_out,
  output logic                                  is_done
);
  import ttdf_pkg::*;

  cmd_t    cmd;
  status_t status;

  ttdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .level    (level),
    .status   (status),
    .cmd      (cmd)
  );

  ttdf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .vertex     (vertex),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .vertex_out (vertex_out),
    .is_done    (is_done)
  );

  // never overwrite a beat that the receiver is still stalling
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output register loaded while its beat is stalled");

  // sweep and tag write share the memory port
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_en && cmd.wr_en))
    else $error("clear sweep and tag write in the same cycle");

  // no input beat accepted while the sweep runs
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_en |-> in_stall)
    else $error("input accepted during clear sweep");

  // a loaded done marker carries a zero id
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && cmd.out_done |=> out_valid && is_done && (vertex_out == '0))
    else $error("done marker with nonzero id");

endmodule

`default_nettype wire

// ===== dv/tb_two_way_tag_duplicate_filter.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for two_way_tag_duplicate_filter: directed beats, then random
// passes under four idle/stall mixes, with results checked against a tag-table predictor.
// Depends on ttdf_pkg and the two_way_tag_duplicate_filter RTL.

module tb_two_way_tag_duplicate_filter;
  import ttdf_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  // a level-0 start sweeps 16384 rows with no beat moving
  localparam int         QUIET_LIMIT = 80000;
  localparam int         PHASE_BEATS = 400;

  typedef struct {
    logic [1:0]             op;
    logic [6:0]             level;
    logic [VERTEX_BITS-1:0] vertex;
  } filter_item_t;

  typedef struct {
    logic [VERTEX_BITS-1:0] vertex_out;
    logic                   is_done;
  } filter_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             op = OP_START;
  logic [6:0]             level = '0;
  logic [VERTEX_BITS-1:0] vertex = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [VERTEX_BITS-1:0] vertex_out;
  logic                   is_done;

  two_way_tag_duplicate_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .level(level), .vertex(vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .vertex_out(vertex_out), .is_done(is_done)
  );

  // predictor state: both tag ways and the round-robin pointer
  logic [TAG_BITS-1:0] way0_tag [DEPTH];
  logic [TAG_BITS-1:0] way1_tag [DEPTH];
  logic                fill_way;

  filter_item_t   stream_q[$];
  filter_result_t fwd_q[$];
  filter_item_t   cur_item;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit send_pause = 1'b0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int beats_in = 0;
  int beats_out = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int n_fwd = 0, n_drop = 0, n_done = 0, n_clear = 0, n_ignored = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_tags();
    for (int i = 0; i < DEPTH; i++) begin
      way0_tag[i] = EMPTY_TAG;
      way1_tag[i] = EMPTY_TAG;
    end
  endtask

  task automatic filter_predict(input filter_item_t b);
    logic [INDEX_BITS-1:0] row;
    logic [TAG_BITS-1:0]   tag;
    row = b.vertex[INDEX_BITS-1:0];
    tag = b.vertex[VERTEX_BITS-1:INDEX_BITS];
    case (b.op)
      OP_START: begin
        fill_way = 1'b0;
        if (b.level == 7'd0) begin
          clear_tags();
          n_clear++;
        end
      end
      OP_VERTEX: begin
        if (way0_tag[row] == tag || way1_tag[row] == tag) begin
          n_drop++;
        end else begin
          if (fill_way) way1_tag[row] = tag;
          else          way0_tag[row] = tag;
          fill_way = ~fill_way;
          fwd_q.push_back('{vertex_out: b.vertex, is_done: 1'b0});
          n_fwd++;
        end
      end
      OP_END: begin
        fwd_q.push_back('{vertex_out: '0, is_done: 1'b1});
        n_done++;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic push_item(input logic [1:0] o, input logic [6:0] l,
                           input logic [VERTEX_BITS-1:0] v);
    stream_q.push_back('{op: o, level: l, vertex: v});
  endtask

  // mostly a few hot rows and tags so hits, evictions and aliasing recur
  function automatic logic [VERTEX_BITS-1:0] pick_vertex();
    logic [INDEX_BITS-1:0] row;
    logic [TAG_BITS-1:0]   tag;
    if ($urandom_range(9) < 3) return $urandom();
    case ($urandom_range(5))
      0: row = '0;
      1: row = '1;
      2: row = 14'h0007;
      3: row = 14'h1234;
      4: row = 14'h2AAA;
      default: row = 14'h1555;
    endcase
    case ($urandom_range(6))
      0: tag = '0;
      1: tag = '1;
      2: tag = 18'd1;
      3: tag = 18'd2;
      4: tag = 18'd3;
      5: tag = EMPTY_TAG;
      default: tag = 18'h2AAAA;
    endcase
    return {tag, row};
  endfunction

  // one BFS pass with noise; returns the number of beats that count
  task automatic queue_pass(output int counted);
    int  len;
    bit  broken;
    logic [6:0] lvl;
    counted = 0;
    broken = ($urandom_range(9) == 0);
    lvl = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127, 1));
    if (!(broken && $urandom_range(1) == 0)) begin
      push_item(OP_START, lvl, $urandom());
      counted++;
    end
    len = $urandom_range(60, 10);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(99))
        0, 1, 2, 3, 4: begin
          push_item(OP_UNUSED, 7'($urandom()), $urandom());
        end
        5, 6, 7: begin
          push_item(OP_END, 7'($urandom()), $urandom());
          counted++;
        end
        8, 9: begin
          push_item(OP_START, 7'($urandom_range(127, 1)), $urandom());
          counted++;
        end
        default: begin
          push_item(OP_VERTEX, 7'($urandom()), pick_vertex());
          counted++;
        end
      endcase
    end
    if (!(broken && $urandom_range(1) == 0)) begin
      push_item(OP_END, 7'($urandom()), $urandom());
      counted++;
    end
  endtask

  task automatic wait_drained();
    while (stream_q.size() != 0 || in_valid || fwd_q.size() != 0) @(negedge clk);
  endtask

  // driver: advance on accept, hold the payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        filter_predict(cur_item);
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (stream_q.size() != 0 && !send_pause && $urandom_range(99) >= send_idle_pct) begin
          cur_item = stream_q.pop_front();
          in_valid <= 1'b1;
          op       <= cur_item.op;
          level    <= cur_item.level;
          vertex   <= cur_item.vertex;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each output beat, drive random and long stalls
  always @(posedge clk) begin
    filter_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (fwd_q.size() == 0) begin
          $error("unexpected beat: vertex_out %h is_done %b", vertex_out, is_done);
          mismatches++;
        end else begin
          want = fwd_q.pop_front();
          if (vertex_out !== want.vertex_out) begin
            $error("vertex_out: expected %h, got %h", want.vertex_out, vertex_out);
            mismatches++;
          end
          if (is_done !== want.is_done) begin
            $error("is_done: expected %b, got %b", want.is_done, is_done);
            mismatches++;
          end
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("FAIL two_way_tag_duplicate_filter");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int counted;
    int got;
    int base;
    clear_tags();
    fill_way = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, eviction, aliasing, pass control, ignored fields
    push_item(OP_VERTEX, 7'd0, 32'h0000_0000);
    push_item(OP_VERTEX, 7'd127, 32'h0000_0000);
    push_item(OP_VERTEX, 7'd0, 32'hFFFF_FFFF);
    push_item(OP_VERTEX, 7'd0, {EMPTY_TAG, 14'd5});
    push_item(OP_VERTEX, 7'd0, {18'd1, 14'd7});
    push_item(OP_VERTEX, 7'd0, {18'd2, 14'd7});
    push_item(OP_VERTEX, 7'd0, {18'd3, 14'd7});
    push_item(OP_VERTEX, 7'd0, {18'd1, 14'd7});
    push_item(OP_VERTEX, 7'd0, {18'd2, 14'd7});
    push_item(OP_UNUSED, 7'd127, 32'h1234_5678);
    push_item(OP_END, 7'd127, 32'hFFFF_FFFF);
    push_item(OP_START, 7'd5, 32'hFFFF_FFFF);
    push_item(OP_VERTEX, 7'd0, {18'd3, 14'd7});
    push_item(OP_VERTEX, 7'd0, {18'd4, 14'd7});
    push_item(OP_START, 7'd0, 32'h0000_0000);
    push_item(OP_VERTEX, 7'd0, 32'h0000_0000);
    push_item(OP_VERTEX, 7'd0, {EMPTY_TAG, 14'd5});
    push_item(OP_VERTEX, 7'd0, 32'hFFFF_FFFF);
    push_item(OP_START, 7'd127, 32'hFFFF_FFFF);
    push_item(OP_VERTEX, 7'd0, 32'hFFFF_FFFF);
    push_item(OP_END, 7'd0, 32'h0000_0000);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      counted = 0;
      while (counted < PHASE_BEATS) begin
        queue_pass(got);
        counted += got;
      end
      if (phase == 0) begin
        // long receiver hold-off while the sender keeps offering beats
        base = beats_in;
        while (beats_in < base + 120) @(negedge clk);
        hold_asks++;
        // then stop sending until the output side is empty
        while (beats_in < base + 300) @(negedge clk);
        send_pause = 1'b1;
        while (in_valid || fwd_q.size() != 0) @(negedge clk);
        send_pause = 1'b0;
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    $display("run: %0d beats in, %0d out; %0d ids forwarded, %0d dropped, %0d done markers",
             beats_in, beats_out, n_fwd, n_drop, n_done);
    $display("run: %0d table clears, %0d unused-op beats ignored, %0d mismatches",
             n_clear, n_ignored, mismatches);
    if (mismatches == 0) begin
      $display("PASS two_way_tag_duplicate_filter");
    end else begin
      $display("FAIL two_way_tag_duplicate_filter");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ttdf_pkg.sv
src/ttdf_ctrl.sv
src/ttdf_datapath.sv
src/two_way_tag_duplicate_filter.sv
dv/tb_two_way_tag_duplicate_filter.sv
